// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL files. Every check is clocked on clock
// and is switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define LEC_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define LEC_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/lec_pkg.sv =====
package lec_pkg;

   localparam int LEDS_PER_COLUMN_DEF = 8;
   localparam int COLUMN_COUNT_DEF    = 6;

   localparam logic [7:0] FULL_LEVEL_RESET = 8'd127;

   localparam logic [2:0] PROG_OFF      = 3'd0;
   localparam logic [2:0] PROG_ON       = 3'd1;
   localparam logic [2:0] PROG_LOOP     = 3'd2;
   localparam logic [2:0] PROG_BLINK    = 3'd3;
   localparam logic [2:0] PROG_FADE_IN  = 3'd4;
   localparam logic [2:0] PROG_FADE_OUT = 3'd5;

   localparam logic [1:0] STEP_INIT = 2'd0;
   localparam logic [1:0] STEP_UP   = 2'd1;
   localparam logic [1:0] STEP_DOWN = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SET_WR,
      ST_TICK,
      ST_PUSH
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0] prog;
      logic [7:0] speed;
      logic [1:0] step;
      logic [7:0] prescale;
      logic [7:0] level;
      logic       led_bit;
   } led_rec_type;

   typedef struct packed {
      led_rec_type rec;
      logic        fin;
   } adv_type;

   typedef struct packed {
      logic load;
      logic rd_en;
      logic rd_set;
      logic wr_set;
      logic wr_tick;
      logic clr_acc;
      logic push;
   } lec_cmd_type;

   typedef struct packed {
      logic is_set;
      logic idx_ok;
      logic col_ok;
      logic out_free;
   } lec_stat_type;

endpackage

// ===== sv/lec_ctrl.sv =====
`include "assert_macros.svh"

module lec_ctrl
   import lec_pkg::*;
#(
   parameter int LEDS_PER_COLUMN = LEDS_PER_COLUMN_DEF,
   localparam int CNT_W = (LEDS_PER_COLUMN > 1) ? $clog2(LEDS_PER_COLUMN) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  lec_stat_type     stat,
   output lec_cmd_type      cmd,
   output logic [CNT_W-1:0] led_sel
);

   localparam logic [CNT_W-1:0] LAST_LED = CNT_W'(LEDS_PER_COLUMN - 1);

   ctrl_state_type   state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_set && stat.idx_ok) begin
               state_in = ST_SET_WR;
            end else if (!stat.is_set && stat.col_ok) begin
               state_in = ST_TICK;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SET_WR: state_in = ST_IDLE;
         ST_TICK: begin
            if (cnt_ff == LAST_LED) begin
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      led_sel    = '0;
      cnt_in     = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_DECODE: begin
            cmd.clr_acc = 1'b1;
            cnt_in      = '0;
            if (stat.is_set && stat.idx_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_set = 1'b1;
            end else if (!stat.is_set && stat.col_ok) begin
               cmd.rd_en = 1'b1;
            end
         end
         ST_SET_WR: cmd.wr_set = 1'b1;
         ST_TICK: begin
            cmd.wr_tick = 1'b1;
            if (cnt_ff != LAST_LED) begin
               cmd.rd_en = 1'b1;
               cnt_in    = CNT_W'(cnt_ff + 1'b1);
               led_sel   = cnt_in;
            end
         end
         ST_PUSH: cmd.push = stat.out_free;
         default: cmd = '0;
      endcase
   end

   `LEC_ASSERT_NXT(a_accept_decodes, req_tvalid && req_tready, state_ff == ST_DECODE,
      "Accepted word did not move to decode.")
   `LEC_ASSERT_IMP(a_tick_count_range, state_ff == ST_TICK, cnt_ff <= LAST_LED,
      "LED counter ran past the column.")
   `LEC_ASSERT_NXT(a_push_returns_idle, cmd.push, state_ff == ST_IDLE,
      "Result push did not return to idle.")

endmodule

// ===== sv/lec_datapath.sv =====
`include "assert_macros.svh"

module lec_datapath
   import lec_pkg::*;
#(
   parameter int LEDS_PER_COLUMN = LEDS_PER_COLUMN_DEF,
   parameter int COLUMN_COUNT    = COLUMN_COUNT_DEF,
   localparam int CNT_W = (LEDS_PER_COLUMN > 1) ? $clog2(LEDS_PER_COLUMN) : 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic [23:0]      req_tdata,
   input  logic             req_tuser,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,
   output logic             rsp_tuser,
   input  lec_cmd_type      cmd,
   input  logic [CNT_W-1:0] led_sel,
   output lec_stat_type     stat
);

   localparam int LED_TOTAL = LEDS_PER_COLUMN * COLUMN_COUNT;
   localparam int ADDR_W    = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;

   logic [7:0]  full_level_ff;
   logic        func_ff;
   logic [2:0]  column_ff;
   logic [3:0]  phase_ff;
   logic [5:0]  led_index_ff;
   logic [2:0]  program_ff;
   logic [7:0]  speed_ff;

   led_rec_type           mem [LED_TOTAL];
   led_rec_type           mem_rd_ff;
   logic [LED_TOTAL-1:0]  valid_ff;
   logic                  rd_valid_ff;
   logic [ADDR_W-1:0]     rd_addr;
   logic [ADDR_W-1:0]     wr_addr_ff;
   logic [CNT_W-1:0]      led_pos_ff;
   logic                  wr_en;
   led_rec_type           rd_rec;
   led_rec_type           wr_rec;
   adv_type               adv;

   logic [LEDS_PER_COLUMN-1:0] pattern_ff;
   logic                       all_fin_ff;

   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [2:0]  column_out_ff;
   logic [7:0]  pattern_out_ff;
   logic        all_fin_out_ff;

   function automatic adv_type advance(led_rec_type r, logic [3:0] ph, logic [7:0] full);
      adv_type    a;
      logic [7:0] pre;
      logic [7:0] lvl;
      logic [1:0] step;
      a     = '{rec: r, fin: 1'b0};
      pre   = r.prescale;
      lvl   = r.level;
      step  = r.step;
      if (r.prog == PROG_OFF) begin
         a.rec.speed    = '0;
         a.rec.step     = STEP_INIT;
         a.rec.prescale = '0;
         a.rec.level    = '0;
         a.rec.led_bit  = 1'b0;
         a.fin          = 1'b1;
      end else if (r.prog == PROG_ON) begin
         a.rec.led_bit = 1'b1;
         a.fin         = 1'b1;
      end else if (r.prog > PROG_FADE_OUT) begin
         a.fin = 1'b1;
      end else begin
         if (step == STEP_INIT) begin
            pre  = '0;
            lvl  = (r.prog == PROG_BLINK) ? 8'd1 :
                   (r.prog == PROG_FADE_OUT) ? full : 8'd0;
            step = STEP_UP;
         end else if (step == STEP_UP) begin
            pre   = 8'(pre + 8'd1);
            a.fin = 1'b1;
            if (r.prog == PROG_BLINK) begin
               if (pre > r.speed) begin
                  pre = '0;
                  lvl = (lvl == 8'd0) ? 8'd1 : 8'd0;
               end
            end else if (r.prog == PROG_FADE_OUT) begin
               if (lvl == 8'd0) begin
                  pre = '0;
               end else if (pre > r.speed) begin
                  pre = '0;
                  lvl = lvl >> 1;
               end
            end else if (lvl > full) begin
               if (r.prog == PROG_LOOP) begin
                  pre  = 8'd1;
                  step = STEP_DOWN;
               end else begin
                  pre = '0;
               end
            end else if (pre > r.speed) begin
               pre = '0;
               lvl = {lvl[6:0], 1'b1};
            end
         end else if (step == STEP_DOWN && r.prog == PROG_LOOP) begin
            pre   = 8'(pre + 8'd1);
            a.fin = 1'b1;
            if (lvl == 8'd0) begin
               pre  = 8'd1;
               step = STEP_UP;
            end else if (pre > r.speed) begin
               pre = '0;
               lvl = lvl >> 1;
            end
         end else begin
            step = STEP_INIT;
         end
         a.rec.step     = step;
         a.rec.prescale = pre;
         a.rec.level    = lvl;
         if (r.prog == PROG_BLINK) begin
            a.rec.led_bit = (lvl != 8'd0);
         end else if (ph != 4'd0 && ph <= 4'd8) begin
            a.rec.led_bit = lvl[3'(ph - 4'd1)];
         end else begin
            a.rec.led_bit = 1'b0;
         end
      end
      return a;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         full_level_ff <= FULL_LEVEL_RESET;
      end else if (csr_wr_en) begin
         full_level_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff      <= req_tuser;
         column_ff    <= req_tdata[2:0];
         phase_ff     <= req_tdata[6:3];
         led_index_ff <= req_tdata[12:7];
         program_ff   <= req_tdata[15:13];
         speed_ff     <= req_tdata[23:16];
      end
   end

   assign stat.is_set   = func_ff;
   assign stat.idx_ok   = int'(led_index_ff) < LED_TOTAL;
   assign stat.col_ok   = int'(column_ff) < COLUMN_COUNT;
   assign stat.out_free = !rsp_tvalid_ff || rsp_tready;

   assign rd_addr = cmd.rd_set ? ADDR_W'(led_index_ff) :
                    ADDR_W'(int'(column_ff) * LEDS_PER_COLUMN + int'(led_sel));

   assign rd_rec = rd_valid_ff ? mem_rd_ff : '0;
   assign adv    = advance(rd_rec, phase_ff, full_level_ff);
   assign wr_en  = cmd.wr_set || cmd.wr_tick;

   always_comb begin
      wr_rec = adv.rec;
      if (cmd.wr_set) begin
         wr_rec       = rd_rec;
         wr_rec.prog  = program_ff;
         wr_rec.speed = speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr_ff] <= wr_rec;
      end
      if (cmd.rd_en) begin
         mem_rd_ff   <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
         wr_addr_ff  <= rd_addr;
         led_pos_ff  <= led_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_acc) begin
         pattern_ff <= '0;
         all_fin_ff <= 1'b1;
      end else if (cmd.wr_tick) begin
         pattern_ff[led_pos_ff] <= adv.rec.led_bit;
         all_fin_ff             <= all_fin_ff & adv.fin;
      end
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.push) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         column_out_ff  <= column_ff;
         pattern_out_ff <= 8'(pattern_ff);
         all_fin_out_ff <= all_fin_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {5'b0, pattern_out_ff, column_out_ff};
   assign rsp_tuser  = all_fin_out_ff;

   `LEC_ASSERT_IMP(a_no_same_addr_rmw, wr_en && cmd.rd_en, wr_addr_ff != rd_addr,
      "Table read and write hit the same LED in one cycle.")
   `LEC_ASSERT_IMP(a_push_into_free_slot, cmd.push, !rsp_tvalid_ff || rsp_tready,
      "Result pushed over a word that was not taken.")
   `LEC_ASSERT_IMP(a_one_write_kind, wr_en, !(cmd.wr_set && cmd.wr_tick),
      "Set write and tick write issued together.")

endmodule

// ===== sv/led_effect_column_engine.sv =====
// LED effect column engine.
// The req channel carries one word per item. req_tuser selects the kind: 1 writes
// the program and speed of one LED, 0 is a column tick that advances all LEDs
// of one column and returns one word on the rsp channel with the column,
// its packed LED bits and a flag that is set when every LED reported finished.
// Writes with an LED index beyond the table and ticks with a column beyond the
// table are dropped and return nothing. The csr port sets the fade-full level.
// A tick passes through decode, a tick state for each LED and a push state that
// waits for a free output register; rsp_tvalid is registered from the push. The
// table is a memory with one read and one write port, read and written back one
// LED record per cycle during a tick. A set word passes through decode and then
// the write state, a dropped word returns to idle from decode. The next word is
// accepted as soon as the result sits in the output register, so a stalled
// receiver holds the engine only when a second result is ready to leave.
// Reset clears the valid bits of the LED table, so every LED reads as program
// off with all state zero, drops any pending result and loads full level 127.
module led_effect_column_engine
   import lec_pkg::*;
#(
   parameter int LEDS_PER_COLUMN = LEDS_PER_COLUMN_DEF,
   parameter int COLUMN_COUNT    = COLUMN_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // column[2:0], phase[6:3], led_index[12:7],
                                    // program_req[15:13], speed[23:16]
   input  logic        req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // column_out[2:0], pattern[10:3], zero[15:11]
   output logic        rsp_tuser    // all_finished[0]
);

   localparam int CNT_W = (LEDS_PER_COLUMN > 1) ? $clog2(LEDS_PER_COLUMN) : 1;

   lec_cmd_type      cmd;
   lec_stat_type     stat;
   logic [CNT_W-1:0] led_sel;

   lec_ctrl #(
      .LEDS_PER_COLUMN(LEDS_PER_COLUMN)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd),
      .led_sel    (led_sel)
   );

   lec_datapath #(
      .LEDS_PER_COLUMN(LEDS_PER_COLUMN),
      .COLUMN_COUNT   (COLUMN_COUNT)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .cmd         (cmd),
      .led_sel     (led_sel),
      .stat        (stat)
   );

endmodule
